// ===== sv/stld_pkg.sv =====
// ----------------------------------------------------------------------------
// stld_pkg
// Shared types and codes for the start/length/end-code frame deframer.
// ----------------------------------------------------------------------------
package stld_pkg;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_BODY
   } phase_type;

   localparam logic [2:0] ST_ACK     = 3'd0;
   localparam logic [2:0] ST_NACK    = 3'd1;
   localparam logic [2:0] ST_INFO    = 3'd2;
   localparam logic [2:0] ST_UNKNOWN = 3'd3;
   localparam logic [2:0] ST_BAD     = 3'd4;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_REPORT  = 1'b1;

   localparam logic [2:0] REG_START_CODE  = 3'd0;
   localparam logic [2:0] REG_END_CODE    = 3'd1;
   localparam logic [2:0] REG_ACK_TYPE    = 3'd2;
   localparam logic [2:0] REG_NACK_TYPE   = 3'd3;
   localparam logic [2:0] REG_INFO_TYPE   = 3'd4;
   localparam logic [2:0] REG_DATA_OFFSET = 3'd5;

   localparam logic [15:0] MIN_LENGTH  = 16'd5;
   localparam logic [15:0] TYPE_OFFSET = 16'd3;
   localparam logic [15:0] ID_OFFSET   = 16'd4;
   localparam logic [3:0]  MIN_DATA_OFFSET = 4'd4;

   typedef struct packed {
      logic [7:0] start_code;
      logic [7:0] end_code;
      logic [7:0] ack_type;
      logic [7:0] nack_type;
      logic [7:0] info_type;
      logic [3:0] data_offset;
   } cfg_type;

   typedef struct packed {
      logic       out_kind;
      logic [7:0] payload_byte;
      logic [7:0] frame_type;
      logic [7:0] info_id;
      logic [2:0] frame_status;
   } rsp_type;

endpackage

// ===== sv/stld_req_if.sv =====
// ----------------------------------------------------------------------------
// stld_req_if
// Request channel: one received byte per request.
// ----------------------------------------------------------------------------
interface stld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/stld_rsp_if.sv =====
// ----------------------------------------------------------------------------
// stld_rsp_if
// Response channel: payload bytes and end of frame reports.
// ----------------------------------------------------------------------------
interface stld_rsp_if;
   logic       valid;
   logic       ready;
   logic       out_kind;
   logic [7:0] payload_byte;
   logic [7:0] frame_type;
   logic [7:0] info_id;
   logic [2:0] frame_status;

   modport source (output valid, output out_kind, output payload_byte,
                   output frame_type, output info_id, output frame_status,
                   input ready);
   modport sink (input valid, input out_kind, input payload_byte,
                 input frame_type, input info_id, input frame_status,
                 output ready);
endinterface

// ===== sv/stld_csr.sv =====
// ----------------------------------------------------------------------------
// stld_csr
// Configuration registers, write only.
// ----------------------------------------------------------------------------
module stld_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [2:0]        index,
   input  logic [7:0]        wdata,
   output stld_pkg::cfg_type cfg
);

   stld_pkg::cfg_type cfg_ff;
   stld_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            stld_pkg::REG_START_CODE:  cfg_in.start_code  = wdata;
            stld_pkg::REG_END_CODE:    cfg_in.end_code    = wdata;
            stld_pkg::REG_ACK_TYPE:    cfg_in.ack_type    = wdata;
            stld_pkg::REG_NACK_TYPE:   cfg_in.nack_type   = wdata;
            stld_pkg::REG_INFO_TYPE:   cfg_in.info_type   = wdata;
            stld_pkg::REG_DATA_OFFSET: cfg_in.data_offset = wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_code  <= 8'd2;
         cfg_ff.end_code    <= 8'd3;
         cfg_ff.ack_type    <= 8'd1;
         cfg_ff.nack_type   <= 8'd2;
         cfg_ff.info_type   <= 8'd3;
         cfg_ff.data_offset <= 4'd5;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/stld_in_reg.sv =====
// ----------------------------------------------------------------------------
// stld_in_reg
// Input register for received bytes.
// ----------------------------------------------------------------------------
module stld_in_reg (
   input  logic        clock,
   input  logic        reset,
   stld_req_if.sink    req,
   input  logic        advance,
   output logic        in_vld,
   output logic [7:0]  in_byte
);

   logic       vld_ff;
   logic       vld_in;
   logic [7:0] byte_ff;
   logic       take;

   assign req.ready = !vld_ff || advance;
   assign take      = req.valid && req.ready;

   always_comb begin
      if (take) begin
         vld_in = 1'b1;
      end else if (advance) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req.rx_byte;
      end
   end

   assign in_vld  = vld_ff;
   assign in_byte = byte_ff;

endmodule

// ===== sv/stld_core.sv =====
// ----------------------------------------------------------------------------
// stld_core
// Frame state machine (hunt, length, body); at most one response per byte.
// ----------------------------------------------------------------------------
module stld_core (
   input  logic              clock,
   input  logic              reset,
   input  stld_pkg::cfg_type cfg,
   input  logic              step,
   input  logic [7:0]        rx_byte,
   output logic              res_vld,
   output stld_pkg::rsp_type res
);

   stld_pkg::phase_type phase_ff, phase_in;
   logic [15:0] frame_length_ff, frame_length_in;
   logic [15:0] byte_position_ff, byte_position_in;
   logic [7:0]  held_type_ff, held_type_in;
   logic [7:0]  held_id_ff, held_id_in;

   logic [3:0]  first;
   logic        final_hit;
   logic [2:0]  status;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= stld_pkg::PH_HUNT;
         frame_length_ff  <= '0;
         byte_position_ff <= '0;
         held_type_ff     <= '0;
         held_id_ff       <= '0;
      end else if (step) begin
         phase_ff         <= phase_in;
         frame_length_ff  <= frame_length_in;
         byte_position_ff <= byte_position_in;
         held_type_ff     <= held_type_in;
         held_id_ff       <= held_id_in;
      end
   end

   assign first = (cfg.data_offset < stld_pkg::MIN_DATA_OFFSET) ?
                  stld_pkg::MIN_DATA_OFFSET : cfg.data_offset;
   assign final_hit = (byte_position_ff == (frame_length_ff - 16'd1));

   always_comb begin
      phase_in         = phase_ff;
      frame_length_in  = frame_length_ff;
      byte_position_in = byte_position_ff;
      held_type_in     = held_type_ff;
      held_id_in       = held_id_ff;
      res_vld          = 1'b0;
      status           = stld_pkg::ST_INFO;
      res.out_kind     = stld_pkg::KIND_REPORT;
      res.payload_byte = '0;

      case (phase_ff)
         stld_pkg::PH_LEN_LO: begin
            frame_length_in  = {8'd0, rx_byte};
            byte_position_in = 16'd2;
            phase_in         = stld_pkg::PH_LEN_HI;
         end
         stld_pkg::PH_LEN_HI: begin
            frame_length_in  = {rx_byte, frame_length_ff[7:0]};
            byte_position_in = stld_pkg::TYPE_OFFSET;
            if (frame_length_in < stld_pkg::MIN_LENGTH) begin
               phase_in = stld_pkg::PH_HUNT;
               res_vld  = 1'b1;
               status   = stld_pkg::ST_BAD;
            end else begin
               phase_in = stld_pkg::PH_BODY;
            end
         end
         stld_pkg::PH_BODY: begin
            if (byte_position_ff == stld_pkg::TYPE_OFFSET) begin
               held_type_in = rx_byte;
            end
            if (byte_position_ff == stld_pkg::ID_OFFSET) begin
               held_id_in = rx_byte;
            end
            if (final_hit) begin
               phase_in = stld_pkg::PH_HUNT;
               res_vld  = 1'b1;
               if (rx_byte != cfg.end_code) begin
                  status = stld_pkg::ST_BAD;
               end else if (held_type_in == cfg.ack_type) begin
                  status = stld_pkg::ST_ACK;
               end else if (held_type_in == cfg.nack_type) begin
                  status = stld_pkg::ST_NACK;
               end else if (held_type_in == cfg.info_type) begin
                  status = stld_pkg::ST_INFO;
               end else begin
                  status = stld_pkg::ST_UNKNOWN;
               end
            end else begin
               byte_position_in = byte_position_ff + 16'd1;
               if (held_type_in == cfg.info_type &&
                   byte_position_ff >= {12'd0, first}) begin
                  res_vld          = 1'b1;
                  res.out_kind     = stld_pkg::KIND_PAYLOAD;
                  res.payload_byte = rx_byte;
               end
            end
         end
         default: begin
            if (rx_byte == cfg.start_code) begin
               phase_in         = stld_pkg::PH_LEN_LO;
               byte_position_in = 16'd1;
               frame_length_in  = '0;
               held_type_in     = '0;
               held_id_in       = '0;
            end else begin
               phase_in = stld_pkg::PH_HUNT;
            end
         end
      endcase

      res.frame_type   = held_type_in;
      res.info_id      = (held_type_in == cfg.info_type) ? held_id_in : 8'd0;
      res.frame_status = status;
   end

endmodule

// ===== sv/stld_out_reg.sv =====
// ----------------------------------------------------------------------------
// stld_out_reg
// Response register driving the response channel.
// ----------------------------------------------------------------------------
module stld_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  stld_pkg::rsp_type res,
   output logic              out_vld,
   stld_rsp_if.source        rsp
);

   logic              vld_ff;
   logic              vld_in;
   stld_pkg::rsp_type rsp_ff;

   assign vld_in = load || (vld_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= res;
      end
   end

   assign out_vld          = vld_ff;
   assign rsp.valid        = vld_ff;
   assign rsp.out_kind     = rsp_ff.out_kind;
   assign rsp.payload_byte = rsp_ff.payload_byte;
   assign rsp.frame_type   = rsp_ff.frame_type;
   assign rsp.info_id      = rsp_ff.info_id;
   assign rsp.frame_status = rsp_ff.frame_status;

endmodule

// ===== sv/stx_length_etx_deframer.sv =====
// ----------------------------------------------------------------------------
// stx_length_etx_deframer
// Parses start code / length / type / id / payload / end code frames from a
// byte stream, passing payload bytes and one status report per frame.
//
//   channel  | direction | carries
//   req_chan | in        | rx_byte
//   rsp_chan | out       | out_kind, payload_byte, frame_type, info_id,
//            |           | frame_status
//   csr_*    | in        | register writes, index 0..5
//
// One request per cycle unless a held response stalls the input; each byte is
// registered in the input register, and its response, built by the frame state
// update as the byte advances, is registered in the output register.
// Synchronous active-high reset clears control state and loads register
// defaults. A held response that is not taken stalls the byte in the input
// register, and with it new requests, whether or not that byte has a response.
// ----------------------------------------------------------------------------
module stx_length_etx_deframer (
   input  logic       clock,
   input  logic       reset,
   stld_req_if.sink   req_chan,
   stld_rsp_if.source rsp_chan,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);

   stld_pkg::cfg_type cfg;
   stld_pkg::rsp_type res;
   logic              in_vld;
   logic [7:0]        in_byte;
   logic              out_vld;
   logic              advance;
   logic              res_vld;

   assign advance = in_vld && (!out_vld || rsp_chan.ready);

   stld_csr u_csr (
      .clock (clock),
      .reset (reset),
      .wr_en (csr_wr_en),
      .index (csr_index),
      .wdata (csr_wdata),
      .cfg   (cfg)
   );

   stld_in_reg u_in_reg (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .advance (advance),
      .in_vld  (in_vld),
      .in_byte (in_byte)
   );

   stld_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step    (advance),
      .rx_byte (in_byte),
      .res_vld (res_vld),
      .res     (res)
   );

   stld_out_reg u_out_reg (
      .clock   (clock),
      .reset   (reset),
      .load    (advance && res_vld),
      .res     (res),
      .out_vld (out_vld),
      .rsp     (rsp_chan)
   );

`ifndef ASSERT_OFF
   a_payload_is_info: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.out_kind == stld_pkg::KIND_PAYLOAD |->
         rsp_chan.frame_status == stld_pkg::ST_INFO)
      else $error("payload response without info status");

   a_report_no_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.out_kind == stld_pkg::KIND_REPORT |->
         rsp_chan.payload_byte == 8'd0)
      else $error("report carries a payload byte");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.frame_status <= stld_pkg::ST_BAD)
      else $error("status code out of range");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      advance && res_vld |=> out_vld)
      else $error("response lost");
`endif

endmodule

// ===== sim/stld_frame_check.sv =====
// ----------------------------------------------------------------------------
// stld_frame_check
// Watches the request, response and register ports of the deframer. It runs
// its own frame parser on every accepted byte to predict payload bytes and
// end of frame reports, then compares each delivered response field by field
// against the oldest prediction still awaited.
// ----------------------------------------------------------------------------
module stld_frame_check (
   input  logic       clock,
   input  logic       reset,
   stld_req_if        req_chan,
   stld_rsp_if        rsp_chan,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata,
   output int         error_count,
   output int         awaited_count
);

   stld_pkg::cfg_type   regs;
   stld_pkg::phase_type phase;
   logic [15:0]         frame_len;
   logic [15:0]         byte_pos;
   logic [7:0]          held_type;
   logic [7:0]          held_id;
   stld_pkg::rsp_type   awaited_q[$];
   int                  fails = 0;

   function automatic stld_pkg::rsp_type frame_word(input logic kind,
                                                    input logic [7:0] pay,
                                                    input logic [2:0] status);
      stld_pkg::rsp_type r;
      r.out_kind     = kind;
      r.payload_byte = pay;
      r.frame_type   = held_type;
      r.info_id      = (held_type == regs.info_type) ? held_id : 8'h00;
      r.frame_status = status;
      return r;
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, output stld_pkg::rsp_type r);
      logic [15:0] pos;
      logic [15:0] first;
      logic [2:0]  status;
      parse_byte = 1'b0;
      r = '0;
      case (phase)
         stld_pkg::PH_LEN_LO: begin
            frame_len = {8'h00, b};
            byte_pos  = 16'd2;
            phase     = stld_pkg::PH_LEN_HI;
         end
         stld_pkg::PH_LEN_HI: begin
            frame_len[15:8] = b;
            byte_pos        = 16'd3;
            if (frame_len < stld_pkg::MIN_LENGTH) begin
               phase      = stld_pkg::PH_HUNT;
               r          = frame_word(stld_pkg::KIND_REPORT, 8'h00, stld_pkg::ST_BAD);
               parse_byte = 1'b1;
            end else begin
               phase = stld_pkg::PH_BODY;
            end
         end
         stld_pkg::PH_BODY: begin
            pos = byte_pos;
            if (pos == stld_pkg::TYPE_OFFSET) held_type = b;
            if (pos == stld_pkg::ID_OFFSET) held_id = b;
            if (pos == frame_len - 16'd1) begin
               phase = stld_pkg::PH_HUNT;
               if (b != regs.end_code) status = stld_pkg::ST_BAD;
               else if (held_type == regs.ack_type) status = stld_pkg::ST_ACK;
               else if (held_type == regs.nack_type) status = stld_pkg::ST_NACK;
               else if (held_type == regs.info_type) status = stld_pkg::ST_INFO;
               else status = stld_pkg::ST_UNKNOWN;
               r          = frame_word(stld_pkg::KIND_REPORT, 8'h00, status);
               parse_byte = 1'b1;
            end else begin
               byte_pos = pos + 16'd1;
               // offsets below the id byte never carry payload
               first = (regs.data_offset < stld_pkg::MIN_DATA_OFFSET) ?
                       stld_pkg::ID_OFFSET : {12'h000, regs.data_offset};
               if (held_type == regs.info_type && pos >= first) begin
                  r          = frame_word(stld_pkg::KIND_PAYLOAD, b, stld_pkg::ST_INFO);
                  parse_byte = 1'b1;
               end
            end
         end
         default: begin
            if (b == regs.start_code) begin
               phase     = stld_pkg::PH_LEN_LO;
               byte_pos  = 16'd1;
               frame_len = 16'h0000;
               held_type = 8'h00;
               held_id   = 8'h00;
            end
         end
      endcase
   endfunction

   function automatic int field_diff(input string name, input logic [7:0] want,
                                     input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      stld_pkg::rsp_type want;
      if (reset) begin
         regs      = '{start_code: 8'h02, end_code: 8'h03, ack_type: 8'h01,
                       nack_type: 8'h02, info_type: 8'h03, data_offset: 4'h5};
         phase     = stld_pkg::PH_HUNT;
         frame_len = 16'h0000;
         byte_pos  = 16'h0000;
         held_type = 8'h00;
         held_id   = 8'h00;
         awaited_q.delete();
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            if (parse_byte(req_chan.rx_byte, want)) awaited_q.push_back(want);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (awaited_q.size() == 0) begin
               $error("response with nothing awaited: kind %0d, status %0d",
                      rsp_chan.out_kind, rsp_chan.frame_status);
               fails++;
            end else begin
               want = awaited_q.pop_front();
               fails += field_diff("out_kind", want.out_kind, rsp_chan.out_kind);
               fails += field_diff("payload_byte", want.payload_byte, rsp_chan.payload_byte);
               fails += field_diff("frame_type", want.frame_type, rsp_chan.frame_type);
               fails += field_diff("info_id", want.info_id, rsp_chan.info_id);
               fails += field_diff("frame_status", want.frame_status, rsp_chan.frame_status);
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               stld_pkg::REG_START_CODE:  regs.start_code  = csr_wdata;
               stld_pkg::REG_END_CODE:    regs.end_code    = csr_wdata;
               stld_pkg::REG_ACK_TYPE:    regs.ack_type    = csr_wdata;
               stld_pkg::REG_NACK_TYPE:   regs.nack_type   = csr_wdata;
               stld_pkg::REG_INFO_TYPE:   regs.info_type   = csr_wdata;
               stld_pkg::REG_DATA_OFFSET: regs.data_offset = csr_wdata[3:0];
               default: ;
            endcase
         end
      end
      error_count   <= fails;
      awaited_count <= awaited_q.size();
   end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the start/length/end-code deframer: a short directed set of
// frames, then random frames, noise, short lengths, wrong end codes and frames
// split across register changes under a series of register settings, and one
// closing info frame with no idling. Random idling on both channels. A
// separate checker predicts and compares all responses.
// ----------------------------------------------------------------------------
module tb;

   localparam int WHOLE = 1 << 17;
   localparam stld_pkg::cfg_type RESET_REGS = '{start_code: 8'h02, end_code: 8'h03,
                                                ack_type: 8'h01, nack_type: 8'h02,
                                                info_type: 8'h03, data_offset: 4'h5};

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [2:0]        csr_index;
   logic [7:0]        csr_wdata;
   int                error_count;
   int                awaited_count;
   stld_pkg::cfg_type regs;
   bit                idle_on;
   int                sent;
   int                ready_hold = 0;

   stld_req_if req_chan ();
   stld_rsp_if rsp_chan ();

   stx_length_etx_deframer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   stld_frame_check i_check (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .awaited_count (awaited_count)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold     <= ready_hold - 1;
         rsp_chan.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         ready_hold     <= $urandom_range(0, 8);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic push_byte(input logic [7:0] b);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent++;
   endtask

   // sends frame offsets from..upto-1; a short length ends the frame after its length
   task automatic send_frame(input logic [15:0] len, input logic [7:0] kind,
                             input logic [7:0] last, input int from, input int upto);
      logic [7:0] b;
      int         stop;
      stop = (len < stld_pkg::MIN_LENGTH) ? 3 : int'(len);
      if (upto < stop) stop = upto;
      for (int k = from; k < stop; k++) begin
         if (k == 0) b = regs.start_code;
         else if (k == 1) b = len[7:0];
         else if (k == 2) b = len[15:8];
         else if (k == 3) b = kind;
         else if (k == int'(len) - 1) b = last;
         else if ($urandom_range(0, 7) == 0) b = regs.start_code;
         else b = 8'($urandom);
         push_byte(b);
      end
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_regs(input stld_pkg::cfg_type c);
      regs = c;
      write_reg(stld_pkg::REG_START_CODE, c.start_code);
      write_reg(stld_pkg::REG_END_CODE, c.end_code);
      write_reg(stld_pkg::REG_ACK_TYPE, c.ack_type);
      write_reg(stld_pkg::REG_NACK_TYPE, c.nack_type);
      write_reg(stld_pkg::REG_INFO_TYPE, c.info_type);
      write_reg(stld_pkg::REG_DATA_OFFSET, {4'($urandom_range(0, 15)), c.data_offset});
      // indexes past the last register are ignored
      write_reg(stld_pkg::REG_DATA_OFFSET + 3'd1 + 3'($urandom_range(0, 1)), 8'($urandom));
      csr_wr_en <= 1'b0;
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      logic [15:0]       len;
      logic [7:0]        kind;
      logic [7:0]        last;
      logic [7:0]        b;
      int                cut;
      int                next_switch;
      int                setting_no;
      int                pick;
      stld_pkg::cfg_type c;

      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = '0;
      idle_on          = 1'b0;
      sent             = 0;
      regs             = RESET_REGS;
      repeat (2) @(posedge clock);
      reset   <= 1'b0;
      idle_on <= 1'b1;

      // directed frames under the reset settings
      push_byte(8'hFF);
      send_frame(stld_pkg::MIN_LENGTH - 16'd1, 8'h00, 8'h00, 0, WHOLE);
      send_frame(stld_pkg::MIN_LENGTH, regs.ack_type, regs.end_code, 0, WHOLE);
      send_frame(stld_pkg::MIN_LENGTH, regs.info_type, regs.end_code, 0, WHOLE);
      send_frame(stld_pkg::MIN_LENGTH + 16'd2, regs.info_type, regs.end_code, 0, WHOLE);
      send_frame(stld_pkg::MIN_LENGTH, regs.nack_type, ~regs.end_code, 0, WHOLE);
      settle();

      next_switch = sent;
      setting_no  = 0;
      while (sent < 1420) begin
         idle_on <= (sent < 1300) && ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 59);
         if (pick < 5) len = 16'($urandom_range(0, 4));
         else if (pick == 5) len = 16'($urandom_range(256, 400));
         else len = 16'($urandom_range(5, 24));
         pick = $urandom_range(0, 7);
         if (pick < 2) kind = regs.ack_type;
         else if (pick == 2) kind = regs.nack_type;
         else if (pick < 6) kind = regs.info_type;
         else kind = 8'($urandom);
         last = ($urandom_range(0, 7) == 0) ? 8'($urandom) : regs.end_code;

         if (sent >= next_switch) begin
            // register change in the middle of a frame, or after a short-length frame
            cut = (len < stld_pkg::MIN_LENGTH) ? WHOLE
                                               : int'($urandom_range(3, int'(len) - 1));
            send_frame(len, kind, last, 0, cut);
            settle();
            {c.start_code, c.end_code, c.ack_type, c.nack_type} = $urandom;
            c.info_type   = 8'($urandom);
            c.data_offset = 4'($urandom);
            case (setting_no)
               0: c = '0;
               1: c = '1;
               2: begin
                  c.ack_type    = c.info_type;
                  c.nack_type   = c.info_type;
                  c.data_offset = stld_pkg::MIN_DATA_OFFSET;
               end
               3: c.data_offset = 4'd8;
               4: c = RESET_REGS;
               default: ;
            endcase
            program_regs(c);
            setting_no++;
            last = ($urandom_range(0, 7) == 0) ? 8'($urandom) : regs.end_code;
            send_frame(len, kind, last, cut, WHOLE);
            next_switch += 150;
         end else if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 5)) begin
               b = 8'($urandom);
               if (b == regs.start_code) b = ~b;
               push_byte(b);
            end
         end else begin
            send_frame(len, kind, last, 0, WHOLE);
         end
      end

      idle_on <= 1'b0;
      send_frame(16'd40, regs.info_type, regs.end_code, 0, WHOLE);
      settle();

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== stx_length_etx_deframer.f =====
sv/stld_pkg.sv
sv/stld_req_if.sv
sv/stld_rsp_if.sv
sv/stld_csr.sv
sv/stld_in_reg.sv
sv/stld_core.sv
sv/stld_out_reg.sv
sv/stx_length_etx_deframer.sv
sim/stld_frame_check.sv
sim/tb.sv
